// ----- rtl/kuz_pkg.sv -----
// Package with the Kuznyechik tables, request codes and round functions.
package kuz_pkg;

    typedef logic [7:0] byte_table_t [256];
    typedef logic [7:0] coef_table_t [16];

    localparam logic [1:0] REQ_ENCRYPT = 2'd0;
    localparam logic [1:0] REQ_DECRYPT = 2'd1;
    localparam logic [1:0] REQ_EXPAND  = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam int         KEY_COUNT = 10;
    localparam int         KEY_AW    = 4;
    localparam logic [KEY_AW-1:0] KEY_FIRST = KEY_AW'(0);
    localparam logic [KEY_AW-1:0] KEY_LAST  = KEY_AW'(KEY_COUNT - 1);
    localparam logic [5:0] STEP_LAST = 6'd32;

    localparam logic [7:0] GF_POLY = 8'hC3;

    localparam byte_table_t SBOX = '{
        8'hFC, 8'hEE, 8'hDD, 8'h11, 8'hCF, 8'h6E, 8'h31, 8'h16,
        8'hFB, 8'hC4, 8'hFA, 8'hDA, 8'h23, 8'hC5, 8'h04, 8'h4D,
        8'hE9, 8'h77, 8'hF0, 8'hDB, 8'h93, 8'h2E, 8'h99, 8'hBA,
        8'h17, 8'h36, 8'hF1, 8'hBB, 8'h14, 8'hCD, 8'h5F, 8'hC1,
        8'hF9, 8'h18, 8'h65, 8'h5A, 8'hE2, 8'h5C, 8'hEF, 8'h21,
        8'h81, 8'h1C, 8'h3C, 8'h42, 8'h8B, 8'h01, 8'h8E, 8'h4F,
        8'h05, 8'h84, 8'h02, 8'hAE, 8'hE3, 8'h6A, 8'h8F, 8'hA0,
        8'h06, 8'h0B, 8'hED, 8'h98, 8'h7F, 8'hD4, 8'hD3, 8'h1F,
        8'hEB, 8'h34, 8'h2C, 8'h51, 8'hEA, 8'hC8, 8'h48, 8'hAB,
        8'hF2, 8'h2A, 8'h68, 8'hA2, 8'hFD, 8'h3A, 8'hCE, 8'hCC,
        8'hB5, 8'h70, 8'h0E, 8'h56, 8'h08, 8'h0C, 8'h76, 8'h12,
        8'hBF, 8'h72, 8'h13, 8'h47, 8'h9C, 8'hB7, 8'h5D, 8'h87,
        8'h15, 8'hA1, 8'h96, 8'h29, 8'h10, 8'h7B, 8'h9A, 8'hC7,
        8'hF3, 8'h91, 8'h78, 8'h6F, 8'h9D, 8'h9E, 8'hB2, 8'hB1,
        8'h32, 8'h75, 8'h19, 8'h3D, 8'hFF, 8'h35, 8'h8A, 8'h7E,
        8'h6D, 8'h54, 8'hC6, 8'h80, 8'hC3, 8'hBD, 8'h0D, 8'h57,
        8'hDF, 8'hF5, 8'h24, 8'hA9, 8'h3E, 8'hA8, 8'h43, 8'hC9,
        8'hD7, 8'h79, 8'hD6, 8'hF6, 8'h7C, 8'h22, 8'hB9, 8'h03,
        8'hE0, 8'h0F, 8'hEC, 8'hDE, 8'h7A, 8'h94, 8'hB0, 8'hBC,
        8'hDC, 8'hE8, 8'h28, 8'h50, 8'h4E, 8'h33, 8'h0A, 8'h4A,
        8'hA7, 8'h97, 8'h60, 8'h73, 8'h1E, 8'h00, 8'h62, 8'h44,
        8'h1A, 8'hB8, 8'h38, 8'h82, 8'h64, 8'h9F, 8'h26, 8'h41,
        8'hAD, 8'h45, 8'h46, 8'h92, 8'h27, 8'h5E, 8'h55, 8'h2F,
        8'h8C, 8'hA3, 8'hA5, 8'h7D, 8'h69, 8'hD5, 8'h95, 8'h3B,
        8'h07, 8'h58, 8'hB3, 8'h40, 8'h86, 8'hAC, 8'h1D, 8'hF7,
        8'h30, 8'h37, 8'h6B, 8'hE4, 8'h88, 8'hD9, 8'hE7, 8'h89,
        8'hE1, 8'h1B, 8'h83, 8'h49, 8'h4C, 8'h3F, 8'hF8, 8'hFE,
        8'h8D, 8'h53, 8'hAA, 8'h90, 8'hCA, 8'hD8, 8'h85, 8'h61,
        8'h20, 8'h71, 8'h67, 8'hA4, 8'h2D, 8'h2B, 8'h09, 8'h5B,
        8'hCB, 8'h9B, 8'h25, 8'hD0, 8'hBE, 8'hE5, 8'h6C, 8'h52,
        8'h59, 8'hA6, 8'h74, 8'hD2, 8'hE6, 8'hF4, 8'hB4, 8'hC0,
        8'hD1, 8'h66, 8'hAF, 8'hC2, 8'h39, 8'h4B, 8'h63, 8'hB6
    };

    localparam coef_table_t LCOEF = '{
        8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
        8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94, 8'h01
    };

    // Inverse S-box, built at elaboration time from the forward table.
    function automatic byte_table_t build_inv_sbox();
        byte_table_t inv;
        for (int i = 0; i < 256; i++)
        begin
            inv[SBOX[i]] = 8'(i);
        end
        return inv;
    endfunction

    localparam byte_table_t SBOX_INV = build_inv_sbox();

    // Multiplication in GF(2^8) modulo x^8+x^7+x^6+x+1.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'h00;
        sh  = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ sh;
            end
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? GF_POLY : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [127:0] sub_fwd(input logic [127:0] x);
        logic [127:0] y;
        for (int i = 0; i < 16; i++)
        begin
            y[8*i +: 8] = SBOX[x[8*i +: 8]];
        end
        return y;
    endfunction

    function automatic logic [127:0] sub_inv(input logic [127:0] x);
        logic [127:0] y;
        for (int i = 0; i < 16; i++)
        begin
            y[8*i +: 8] = SBOX_INV[x[8*i +: 8]];
        end
        return y;
    endfunction

    // One step of the linear feedback register: shift up, new byte 0.
    function automatic logic [127:0] r_fwd(input logic [127:0] x);
        logic [7:0] acc;
        acc = x[127:120];
        for (int i = 0; i < 15; i++)
        begin
            acc = acc ^ gf_mul(x[8*i +: 8], LCOEF[i]);
        end
        return {x[119:0], acc};
    endfunction

    // Inverse step: shift down, new byte 15.
    function automatic logic [127:0] r_inv(input logic [127:0] x);
        logic [7:0] acc;
        acc = x[7:0];
        for (int i = 0; i < 15; i++)
        begin
            acc = acc ^ gf_mul(x[8*(i+1) +: 8], LCOEF[i]);
        end
        return {acc, x[127:8]};
    endfunction

    // A quarter of the linear map L: four register steps.
    function automatic logic [127:0] lin4_fwd(input logic [127:0] x);
        return r_fwd(r_fwd(r_fwd(r_fwd(x))));
    endfunction

    function automatic logic [127:0] lin4_inv(input logic [127:0] x);
        return r_inv(r_inv(r_inv(r_inv(x))));
    endfunction

endpackage

// ----- rtl/kuznyechik_block_cipher_top.sv -----
// Kuznyechik block cipher with round keys in on-chip memory and an APB key port.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------------
//  request   | start, busy, req_type, block_lo/hi      | item taken when start & !busy
//  result    | done, result_lo, result_hi              | one-cycle strobe, no back-pressure
//  config    | psel, penable, pwrite, paddr, pwdata,   | APB write on access cycle,
//            | prdata, pready                          | pready tied high
//
// The linear map L runs as sixteen feedback-register steps, four per cycle. An
// encrypt or decrypt item keeps busy high for nine rounds plus the final key
// addition, and its result appears with done as busy goes low.
// A key expansion computes each of 32 schedule steps in two parts (first the step
// constant, then the round function) and writes two round keys, in states KSA and
// KSB, after every eighth step and at the start.
// Round keys live in two 10 x 64-bit memories (low and high halves) with
// registered reads; the next round's key is fetched during the last cycle of each
// round. Reset clears the control state and the key words; the round-key memories
// hold nothing valid until the first expansion. The result side cannot stall.
module kuznyechik_block_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] block_lo,
    input  logic [63:0] block_hi,
    output logic        done,
    output logic [63:0] result_lo,
    output logic [63:0] result_hi,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENC  = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_KX   = 3'd3;
    localparam logic [2:0] ST_KSA  = 3'd4;
    localparam logic [2:0] ST_KSB  = 3'd5;

    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_RLAST = 3'd3;
    localparam logic [2:0] PH_FUNC  = 3'd4;
    localparam logic [2:0] PH_KLAST = 3'd7;

    logic [63:0]  kw0_reg, kw1_reg, kw2_reg, kw3_reg;
    logic [2:0]   state_reg, state_next;
    logic [2:0]   ph_reg, ph_next;
    logic [kuz_pkg::KEY_AW-1:0] kidx_reg, kidx_next;
    logic [5:0]   step_reg, step_next;
    logic [127:0] blk_reg, blk_next;
    logic [127:0] left_reg, left_next;
    logic [127:0] right_reg, right_next;
    logic [127:0] res_reg, res_next;
    logic         done_reg, done_next;

    logic [63:0]  key_lo_mem [kuz_pkg::KEY_COUNT];
    logic [63:0]  key_hi_mem [kuz_pkg::KEY_COUNT];
    logic [63:0]  rk_lo_reg, rk_hi_reg;
    logic [kuz_pkg::KEY_AW-1:0] rd_addr, wr_addr;
    logic [127:0] wr_data;
    logic         mem_we;
    logic [127:0] rk;
    logic         cfg_we;

    assign rk     = {rk_hi_reg, rk_lo_reg};
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result_lo = res_reg[63:0];
    assign result_hi = res_reg[127:64];
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // Key words from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw0_reg <= '0;
            kw1_reg <= '0;
            kw2_reg <= '0;
            kw3_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:3])
                REG_KEY0: kw0_reg <= pwdata;
                REG_KEY1: kw1_reg <= pwdata;
                REG_KEY2: kw2_reg <= pwdata;
                REG_KEY3: kw3_reg <= pwdata;
                default:  kw0_reg <= kw0_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_KEY0: prdata = kw0_reg;
            REG_KEY1: prdata = kw1_reg;
            REG_KEY2: prdata = kw2_reg;
            REG_KEY3: prdata = kw3_reg;
            default:  prdata = '0;
        endcase
    end

    // Round-key memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_lo_mem[wr_addr] <= wr_data[63:0];
            key_hi_mem[wr_addr] <= wr_data[127:64];
        end
        rk_lo_reg <= key_lo_mem[rd_addr];
        rk_hi_reg <= key_hi_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        kidx_next  = kidx_reg;
        step_next  = step_reg;
        blk_next   = blk_reg;
        left_next  = left_reg;
        right_next = right_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        rd_addr    = kidx_reg;
        mem_we     = 1'b0;
        wr_addr    = step_reg[5:2];
        wr_data    = left_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ph_next = PH_FIRST;
                    case (req_type)
                        kuz_pkg::REQ_ENCRYPT:
                        begin
                            blk_next   = {block_hi, block_lo};
                            kidx_next  = kuz_pkg::KEY_FIRST;
                            rd_addr    = kuz_pkg::KEY_FIRST;
                            state_next = ST_ENC;
                        end
                        kuz_pkg::REQ_DECRYPT:
                        begin
                            blk_next   = {block_hi, block_lo};
                            kidx_next  = kuz_pkg::KEY_LAST;
                            rd_addr    = kuz_pkg::KEY_LAST;
                            state_next = ST_DEC;
                        end
                        kuz_pkg::REQ_EXPAND:
                        begin
                            left_next  = {kw1_reg, kw0_reg};
                            right_next = {kw3_reg, kw2_reg};
                            step_next  = '0;
                            state_next = ST_KSA;
                        end
                        default:
                        begin
                            // Unused request code: an all-zero result, nothing else.
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_ENC:
            begin
                if (ph_reg == PH_FIRST)
                begin
                    if (kidx_reg == kuz_pkg::KEY_LAST)
                    begin
                        res_next   = blk_reg ^ rk;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        blk_next = kuz_pkg::lin4_fwd(kuz_pkg::sub_fwd(blk_reg ^ rk));
                        ph_next  = ph_reg + 3'd1;
                    end
                end
                else if (ph_reg == PH_RLAST)
                begin
                    blk_next  = kuz_pkg::lin4_fwd(blk_reg);
                    rd_addr   = kidx_reg + 1'b1;
                    kidx_next = kidx_reg + 1'b1;
                    ph_next   = PH_FIRST;
                end
                else
                begin
                    blk_next = kuz_pkg::lin4_fwd(blk_reg);
                    ph_next  = ph_reg + 3'd1;
                end
            end

            ST_DEC:
            begin
                if (ph_reg == PH_FIRST)
                begin
                    if (kidx_reg == kuz_pkg::KEY_FIRST)
                    begin
                        res_next   = blk_reg ^ rk;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        blk_next = kuz_pkg::lin4_inv(blk_reg ^ rk);
                        ph_next  = ph_reg + 3'd1;
                    end
                end
                else if (ph_reg == PH_RLAST)
                begin
                    blk_next  = kuz_pkg::sub_inv(kuz_pkg::lin4_inv(blk_reg));
                    rd_addr   = kidx_reg - 1'b1;
                    kidx_next = kidx_reg - 1'b1;
                    ph_next   = PH_FIRST;
                end
                else
                begin
                    blk_next = kuz_pkg::lin4_inv(blk_reg);
                    ph_next  = ph_reg + 3'd1;
                end
            end

            ST_KX:
            begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg == PH_FIRST)
                begin
                    // Step constant: L applied to the step number in byte 15.
                    blk_next = kuz_pkg::lin4_fwd({2'b00, step_reg, 120'd0});
                end
                else if (ph_reg == PH_FUNC)
                begin
                    blk_next = kuz_pkg::lin4_fwd(kuz_pkg::sub_fwd(left_reg ^ blk_reg));
                end
                else if (ph_reg == PH_KLAST)
                begin
                    left_next  = kuz_pkg::lin4_fwd(blk_reg) ^ right_reg;
                    right_next = left_reg;
                    if (step_reg[2:0] == 3'd0)
                    begin
                        state_next = ST_KSA;
                    end
                    else
                    begin
                        step_next = step_reg + 6'd1;
                    end
                end
                else
                begin
                    blk_next = kuz_pkg::lin4_fwd(blk_reg);
                end
            end

            ST_KSA:
            begin
                mem_we     = 1'b1;
                wr_addr    = step_reg[5:2];
                wr_data    = left_reg;
                state_next = ST_KSB;
            end

            ST_KSB:
            begin
                mem_we  = 1'b1;
                wr_addr = step_reg[5:2] + 1'b1;
                wr_data = right_reg;
                ph_next = PH_FIRST;
                if (step_reg == kuz_pkg::STEP_LAST)
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next  = step_reg + 6'd1;
                    state_next = ST_KX;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_FIRST;
            kidx_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            kidx_reg  <= kidx_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg   <= blk_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        res_reg   <= res_next;
    end

    // A result strobe always leaves the block ready for the next item.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while still working");

    // The round-key index never leaves the ten stored keys during a cipher pass.
    a_kidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ENC) || (state_reg == ST_DEC)) |-> (kidx_reg <= kuz_pkg::KEY_LAST))
        else $error("round-key index out of range");

    // Work only begins from an accepted request.
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // Key writes happen only during expansion and stay inside the key store.
    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wr_addr <= kuz_pkg::KEY_LAST))
        else $error("round-key write out of range");

endmodule

// ----- tb/tb_kuznyechik_block_cipher_top.sv -----
// Self-checking testbench for the Kuznyechik block cipher with its APB key port.
module tb_kuznyechik_block_cipher_top;

    // Cipher model and store of expected cipher outputs; it counts every failure it sees.
    class cipher_scoreboard;
        logic [63:0]  key_words [4];
        logic [127:0] round_key [10];
        logic [7:0]   sbox_back [256];
        logic [127:0] pending_out [$];
        int           failures;

        function new();
            for (int i = 0; i < 256; i++)
            begin
                sbox_back[kuz_pkg::SBOX[i]] = 8'(i);
            end
            foreach (key_words[i]) key_words[i] = '0;
            foreach (round_key[i]) round_key[i] = '0;
            failures = 0;
        endfunction

        function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
            logic [7:0] acc;
            acc = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (b[i]) acc ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'hC3 : 8'h00);
            end
            return acc;
        endfunction

        function automatic logic [127:0] mix_fwd(logic [127:0] x);
            logic [7:0] acc;
            for (int j = 0; j < 16; j++)
            begin
                acc = x[127:120];
                for (int i = 0; i < 15; i++) acc ^= gmul(x[8*i +: 8], kuz_pkg::LCOEF[i]);
                x = {x[119:0], acc};
            end
            return x;
        endfunction

        function automatic logic [127:0] mix_back(logic [127:0] x);
            logic [7:0] acc;
            for (int j = 0; j < 16; j++)
            begin
                acc = x[7:0];
                for (int i = 0; i < 15; i++)
                    acc ^= gmul(x[8*(i+1) +: 8], kuz_pkg::LCOEF[i]);
                x = {acc, x[127:8]};
            end
            return x;
        endfunction

        function automatic logic [127:0] subst(logic [127:0] x, bit inverse);
            for (int i = 0; i < 16; i++)
            begin
                x[8*i +: 8] = inverse ? sbox_back[x[8*i +: 8]] : kuz_pkg::SBOX[x[8*i +: 8]];
            end
            return x;
        endfunction

        function void schedule_keys();
            logic [127:0] left, right, rc, z;
            left  = {key_words[1], key_words[0]};
            right = {key_words[3], key_words[2]};
            round_key[0] = left;
            round_key[1] = right;
            for (int step = 1; step <= 32; step++)
            begin
                rc = mix_fwd({8'(step), 120'd0});
                z = mix_fwd(subst(left ^ rc, 1'b0)) ^ right;
                right = left;
                left  = z;
                if (step % 8 == 0)
                begin
                    round_key[step/4]     = left;
                    round_key[step/4 + 1] = right;
                end
            end
        endfunction

        // Notes an accepted item and queues the output it must produce.
        function void note_item(logic [1:0] req, logic [63:0] lo, logic [63:0] hi);
            logic [127:0] b;
            b = {hi, lo};
            case (req)
                kuz_pkg::REQ_ENCRYPT:
                begin
                    for (int r = 0; r < 9; r++) b = mix_fwd(subst(b ^ round_key[r], 1'b0));
                    b ^= round_key[9];
                end
                kuz_pkg::REQ_DECRYPT:
                begin
                    for (int r = 9; r > 0; r--) b = subst(mix_back(b ^ round_key[r]), 1'b1);
                    b ^= round_key[0];
                end
                kuz_pkg::REQ_EXPAND:
                begin
                    schedule_keys();
                    b = '0;
                end
                default: b = '0;
            endcase
            pending_out.push_back(b);
        endfunction

        function void check_result(logic [63:0] lo, logic [63:0] hi);
            logic [127:0] want;
            if (pending_out.size() == 0)
            begin
                failures++;
                if (failures <= 10) $display("unexpected result lo=%h hi=%h", lo, hi);
                return;
            end
            want = pending_out.pop_front();
            if (want[63:0] !== lo || want[127:64] !== hi)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected lo=%h hi=%h, got lo=%h hi=%h",
                             want[63:0], want[127:64], lo, hi);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [63:0] block_lo;
    logic [63:0] block_hi;
    logic        done;
    logic [63:0] result_lo;
    logic [63:0] result_hi;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cipher_scoreboard cipher_sb = new();

    // Chance in percent, per cycle, that the sender stays idle before its next item.
    int gap_pct;

    kuznyechik_block_cipher_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .block_lo  (block_lo),
        .block_hi  (block_hi),
        .done      (done),
        .result_lo (result_lo),
        .result_hi (result_hi),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Both monitors sample at the rising edge; inputs only move at the falling edge,
    // so an item is taken exactly when start is high and busy is low here.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy) cipher_sb.note_item(req_type, block_lo, block_hi);
        if (rst_n && done) cipher_sb.check_result(result_lo, result_hi);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Presents one item and holds it until the block takes it. Start stays high
    // afterwards, so back-to-back items see no gap unless idle cycles are drawn.
    task automatic send_item(logic [1:0] req, logic [63:0] lo, logic [63:0] hi);
        @(negedge clk);
        start    = 1'b1;
        req_type = req;
        block_lo = lo;
        block_hi = hi;
        do @(posedge clk); while (busy);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Waits until every queued output has come back and the block is idle.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (cipher_sb.pending_out.size() != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // A key write: setup cycle, then access cycle; the model takes it at that edge.
    task automatic write_key(int idx, logic [63:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(8 * idx);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (pready) cipher_sb.key_words[idx] = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Loads a full key while idle and expands it.
    task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3);
        drain();
        write_key(0, k0);
        write_key(1, k1);
        write_key(2, k2);
        write_key(3, k3);
        send_item(kuz_pkg::REQ_EXPAND, rand64(), rand64());
    endtask

    initial
    begin
        logic [1:0] req;
        int         pick;
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = kuz_pkg::REQ_ENCRYPT;
        block_lo = '0;
        block_hi = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        gap_pct  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The round keys are undefined until the first expansion,
        // so the reset key (all zero) is expanded before any block goes in.
        send_item(kuz_pkg::REQ_EXPAND, '1, '1);
        send_item(kuz_pkg::REQ_ENCRYPT, '0, '0);
        send_item(kuz_pkg::REQ_ENCRYPT, '1, '1);
        send_item(kuz_pkg::REQ_DECRYPT, '0, '0);
        send_item(kuz_pkg::REQ_DECRYPT, '1, '1);
        send_item(kuz_pkg::REQ_UNUSED, '1, '1);   // zero output, no state change
        send_item(kuz_pkg::REQ_ENCRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        load_key('1, '1, '1, '1);
        send_item(kuz_pkg::REQ_ENCRYPT, '0, '1);
        send_item(kuz_pkg::REQ_DECRYPT, '1, '0);
        // A fixed key and block with mixed byte values.
        load_key(64'hFFEE_DDCC_BBAA_9988, 64'h7766_5544_3322_1100,
                 64'h1032_5476_FEDC_BA98, 64'hEFCD_AB89_6745_2301);
        send_item(kuz_pkg::REQ_ENCRYPT, 64'h0077_6655_4433_2211, 64'h8899_AABB_CCEE_FF0A);
        send_item(kuz_pkg::REQ_DECRYPT, 64'h0077_6655_4433_2211, 64'h8899_AABB_CCEE_FF0A);
        send_item(kuz_pkg::REQ_EXPAND, '0, '0);   // same key again, block ignored
        send_item(kuz_pkg::REQ_ENCRYPT, 64'h1, 64'h8000_0000_0000_0000);

        // Random part in four idling phases; each starts with a fresh key.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: gap_pct = 0;
                1: gap_pct = 86;
                2: gap_pct = 0;
                default: gap_pct = 23;
            endcase
            case (phase)
                0: load_key('0, '0, '0, '0);
                1: load_key('1, '1, '1, '1);
                default: load_key(rand64(), rand64(), rand64(), rand64());
            endcase
            for (int n = 0; n < 500; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 46)      req = kuz_pkg::REQ_ENCRYPT;
                else if (pick < 92) req = kuz_pkg::REQ_DECRYPT;
                else if (pick < 96) req = kuz_pkg::REQ_EXPAND;
                else                req = kuz_pkg::REQ_UNUSED;
                send_item(req, rand64(), rand64());
                // Once per phase the sender holds off until the block has drained.
                if (n == 250) drain();
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (cipher_sb.pending_out.size() != 0) cipher_sb.failures++;
        if (cipher_sb.failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/kuz_pkg.sv
rtl/kuznyechik_block_cipher_top.sv
tb/tb_kuznyechik_block_cipher_top.sv
